// File: sv/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg : shared types and constants of the sequential channel fader
// Item and result beats, configuration and walk state, operation and mode
// codes.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

  localparam int DUTY_W = 12;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ON     = 3'd1,
    OP_OFF    = 3'd2,
    OP_BLINK  = 3'd3,
    OP_TOGGLE = 3'd4
  } op_t;

  // Walk modes
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ON    = 2'd1,
    MODE_OFF   = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_TARGET_DUTY   = 2'd0,
    REG_RAMP_STEP     = 2'd1,
    REG_HOLD_TIME     = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic        reverse_order;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              pwm_write;
    logic [3:0]        channel;
    logic [DUTY_W-1:0] duty;
    logic              lamp_on;
    logic              busy_res;
  } result_t;

  typedef struct packed {
    logic [DUTY_W-1:0] target_duty;
    logic [DUTY_W-1:0] ramp_step;
    logic [31:0]       hold_time_ms;
    logic [4:0]        channel_count;
  } cfg_t;

  // Walk state, apart from the channel index whose width is parameterised
  typedef struct packed {
    mode_t           mode;
    logic            pending;
    logic            is_on;
    logic            walk_reverse;
    logic [DUTY_W:0] current_duty;
    logic [31:0]     last_time;
  } walk_state_t;

endpackage : scf_pkg

`default_nettype wire

// File: sv/scf_cfg_regs.sv
// ----------------------------------------------------------------------------
// scf_cfg_regs : configuration register file
// APB-style write and read access to target duty, ramp step, hold time and
// channel count.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_cfg_regs
  import scf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic   wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_duty   <= DUTY_W'(4095);
      cfg.ramp_step     <= DUTY_W'(20);
      cfg.hold_time_ms  <= 32'd10000;
      cfg.channel_count <= 5'd16;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET_DUTY:   cfg.target_duty   <= pwdata[DUTY_W-1:0];
        REG_RAMP_STEP:     cfg.ramp_step     <= pwdata[DUTY_W-1:0];
        REG_HOLD_TIME:     cfg.hold_time_ms  <= pwdata;
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_TARGET_DUTY:   prdata = 32'(cfg.target_duty);
      REG_RAMP_STEP:     prdata = 32'(cfg.ramp_step);
      REG_HOLD_TIME:     prdata = cfg.hold_time_ms;
      REG_CHANNEL_COUNT: prdata = 32'(cfg.channel_count);
      default:           prdata = '0;
    endcase
  end

endmodule : scf_cfg_regs

`default_nettype wire

// File: sv/scf_step.sv
// ----------------------------------------------------------------------------
// scf_step : next-state and result logic for one item
// Ramps the current channel's duty, walks to the next channel, starts and
// finishes walks, and times the blink hold.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_step
  import scf_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int CH_W         = $clog2(MAX_CHANNELS + 2) + 1
)(
  input  wire item_t                  item,
  input  wire cfg_t                   cfg,
  input  wire walk_state_t            st,
  input  wire logic signed [CH_W-1:0] chan,
  output walk_state_t                 st_next,
  output logic signed [CH_W-1:0]      chan_next,
  output result_t                     res
);

  logic signed [CH_W-1:0] eff;        // clamped channel count
  logic signed [CH_W-1:0] start_fwd;  // start index for an upward walk
  logic signed [CH_W-1:0] start_rev;  // start index for a downward walk
  logic signed [CH_W-1:0] ch_adv;
  logic                   adv_in;
  logic                   adv_done;
  logic [DUTY_W:0]        tgt;
  logic [DUTY_W:0]        stp;
  logic [DUTY_W+1:0]      up_sum;
  logic                   up_below;
  logic [DUTY_W:0]        up_duty;
  logic [DUTY_W:0]        dn_duty;
  logic [31:0]            elapsed;
  logic                   wr;
  logic signed [CH_W-1:0] wr_ch;
  logic [DUTY_W:0]        wr_duty;
  logic signed [CH_W+3:0] wr_ch_ext;
  logic                   up_fin;

  // Clamp the channel count to 1 .. MAX_CHANNELS
  always_comb begin
    if (cfg.channel_count == 5'd0) begin
      eff = CH_W'(1);
    end else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) begin
      eff = CH_W'(MAX_CHANNELS);
    end else begin
      eff = CH_W'(cfg.channel_count);
    end
  end

  assign start_fwd = '0;
  assign start_rev = eff - CH_W'(1);

  // Move to the neighbouring channel and check the range
  assign ch_adv   = st.walk_reverse ? chan - CH_W'(1) : chan + CH_W'(1);
  assign adv_in   = (ch_adv >= 0) && (ch_adv < eff);
  assign adv_done = st.walk_reverse ? (ch_adv < 0) : (ch_adv >= eff);

  // Ramp arithmetic
  assign tgt      = {1'b0, cfg.target_duty};
  assign stp      = {1'b0, cfg.ramp_step};
  assign up_sum   = {1'b0, st.current_duty} + {1'b0, stp};
  assign up_below = st.current_duty < tgt;
  assign up_duty  = (up_sum > {1'b0, tgt}) ? tgt : up_sum[DUTY_W:0];
  assign dn_duty  = (st.current_duty > stp) ? st.current_duty - stp : '0;
  assign elapsed  = item.now_ms - st.last_time;

  always_comb begin
    st_next   = st;
    chan_next = chan;
    wr        = 1'b0;
    wr_ch     = '0;
    wr_duty   = '0;
    up_fin    = 1'b0;

    case (op_t'(item.operation)) inside
      OP_ON, OP_OFF, OP_BLINK, OP_TOGGLE: begin
        st_next.walk_reverse = item.reverse_order;
        if (!st.pending) begin
          // start of an on, off or blink walk
          if ((op_t'(item.operation) == OP_ON && !st.is_on) ||
              (op_t'(item.operation) == OP_TOGGLE && !st.is_on)) begin
            st_next.pending      = 1'b1;
            st_next.mode         = MODE_ON;
            st_next.last_time    = item.now_ms;
            st_next.current_duty = '0;
            chan_next = item.reverse_order ? start_rev : start_fwd;
          end else if ((op_t'(item.operation) == OP_OFF && st.is_on) ||
                       (op_t'(item.operation) == OP_TOGGLE && st.is_on)) begin
            st_next.pending      = 1'b1;
            st_next.mode         = MODE_OFF;
            st_next.last_time    = item.now_ms;
            st_next.current_duty = tgt;
            chan_next = item.reverse_order ? start_rev : start_fwd;
          end else if (op_t'(item.operation) == OP_BLINK) begin
            st_next.pending      = 1'b1;
            st_next.mode         = MODE_BLINK;
            st_next.current_duty = '0;
            chan_next = item.reverse_order ? start_rev : start_fwd;
          end
        end
      end

      OP_TICK: begin
        unique case (st.mode) inside
          MODE_ON, MODE_BLINK: begin
            if (st.mode == MODE_BLINK && st.is_on) begin
              // hold time over: start the off walk
              if (elapsed >= cfg.hold_time_ms) begin
                st_next.pending      = 1'b1;
                st_next.mode         = MODE_OFF;
                st_next.last_time    = item.now_ms;
                st_next.current_duty = tgt;
                chan_next = st.walk_reverse ? start_rev : start_fwd;
              end
            end else begin
              // ramp up, then walk on
              if (up_below) begin
                st_next.current_duty = up_duty;
                wr      = 1'b1;
                wr_ch   = chan;
                wr_duty = up_duty;
              end else begin
                chan_next = ch_adv;
                if (adv_in) begin
                  st_next.current_duty = '0;
                  wr    = 1'b1;
                  wr_ch = ch_adv;
                end
                up_fin = adv_done;
              end
              if (st.mode == MODE_BLINK) begin
                st_next.is_on     = up_fin;
                st_next.last_time = item.now_ms;
              end else if (up_fin) begin
                st_next.is_on   = 1'b1;
                st_next.pending = 1'b0;
                st_next.mode    = MODE_IDLE;
              end
            end
          end

          MODE_OFF: begin
            // ramp down, then walk on
            if (st.current_duty != '0) begin
              st_next.current_duty = dn_duty;
              wr      = 1'b1;
              wr_ch   = chan;
              wr_duty = dn_duty;
            end else begin
              chan_next = ch_adv;
              if (adv_in) begin
                st_next.current_duty = tgt;
                wr      = 1'b1;
                wr_ch   = ch_adv;
                wr_duty = tgt;
              end
              if (adv_done) begin
                st_next.is_on   = 1'b0;
                st_next.pending = 1'b0;
                st_next.mode    = MODE_IDLE;
              end
            end
          end

          default: ;
        endcase
      end

      // unknown codes leave everything alone
      default: ;
    endcase
  end

  // Result: channel field is the index's low four bits
  assign wr_ch_ext     = (CH_W+4)'(wr_ch);
  assign res.pwm_write = wr;
  assign res.channel   = wr_ch_ext[3:0];
  assign res.duty      = wr_duty[DUTY_W-1:0];
  assign res.lamp_on   = st_next.is_on;
  assign res.busy_res  = st_next.pending;

endmodule : scf_step

`default_nettype wire

// File: sv/sequential_channel_fader.sv
// ----------------------------------------------------------------------------
// sequential_channel_fader : sequential PWM channel fader
// Input register, single-pass step logic with walk state, result register.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side is not stalled; each item
// gives exactly one result beat: the item register feeds the step logic
// and the result register loads from it. The walk state updates as the
// result is registered, so back-to-back items see each other's effects in
// order. A stalled result register holds the item register, which then
// raises item_stall. Configuration is through the APB port (pready always
// high) and is meant to be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_channel_fader
  import scf_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CH_W = $clog2(MAX_CHANNELS + 2) + 1;

  cfg_t                   cfg;
  item_t                  item_r;
  logic                   item_full;
  logic                   step_en;
  walk_state_t            st;
  walk_state_t            st_next;
  logic signed [CH_W-1:0] chan;
  logic signed [CH_W-1:0] chan_next;
  result_t                res;

  scf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipe advances unless a finished result is held
  assign step_en    = item_full && !(result_valid && result_stall);
  assign item_stall = item_full && !step_en;

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (step_en) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_r <= item;
    end
  end

  scf_step #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CH_W         (CH_W)
  ) u_step (
    .item      (item_r),
    .cfg       (cfg),
    .st        (st),
    .chan      (chan),
    .st_next   (st_next),
    .chan_next (chan_next),
    .res       (res)
  );

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode         <= MODE_IDLE;
      st.pending      <= 1'b0;
      st.is_on        <= 1'b0;
      st.walk_reverse <= 1'b0;
      st.current_duty <= '0;
      st.last_time    <= '0;
      chan            <= '0;
    end else if (step_en) begin
      st   <= st_next;
      chan <= chan_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_en) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result <= res;
    end
  end

  // A walk is in progress exactly while a request is pending
  a_pending_mode: assert property (@(posedge clk) disable iff (rst)
    st.pending == (st.mode != MODE_IDLE))
    else $error("pending flag and walk mode disagree");

  // No write means an all-zero channel and duty
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.pwm_write |-> result.channel == 4'd0 && result.duty == '0)
    else $error("result without write carries channel or duty");

  // A held item is kept until the result side frees up
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_full && !step_en |=> item_full && $stable(item_r))
    else $error("item register lost while pipe was stalled");

  // The reported lamp and busy flags follow the state written with them
  a_flags_track: assert property (@(posedge clk) disable iff (rst)
    step_en |=> result.lamp_on == st.is_on && result.busy_res == st.pending)
    else $error("result flags differ from walk state");

endmodule : sequential_channel_fader

`default_nettype wire

// File: test/fade_walk_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fade_walk_monitor : result predictor and comparator for the channel fader
// Follows register writes on the APB port and every item beat that the fader
// accepts, works out the PWM write, lamp and busy flags each beat must give,
// and checks the result beats against them in order.
// ----------------------------------------------------------------------------

module fade_walk_monitor
  import scf_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned fault_count,
  output int unsigned awaiting
);

  // Register copy
  logic [DUTY_W-1:0] tgt_duty;
  logic [DUTY_W-1:0] step;
  logic [31:0]       hold_ms;
  logic [4:0]        chan_count;

  // Walk state copy
  mode_t           walk_mode;
  bit              pend;
  bit              lamp;
  bit              rev;
  logic [DUTY_W:0] duty_now;
  int              chan_now;
  logic [31:0]     stamp_ms;

  // Duty write of the beat being predicted
  bit                wr_hit;
  logic [3:0]        wr_ch;
  logic [DUTY_W-1:0] wr_dt;

  result_t expected_q[$];
  result_t oldest;

  initial fault_count = 0;

  function automatic int active_channels();
    int c;
    c = chan_count;
    if (c == 0) c = 1;
    if (c > MAX_CHANNELS) c = MAX_CHANNELS;
    return c;
  endfunction

  function automatic void write_duty(logic [DUTY_W:0] d);
    wr_hit = 1'b1;
    wr_ch  = chan_now[3:0];
    wr_dt  = d[DUTY_W-1:0];
  endfunction

  // Step to the next channel; true once the walk has run off the end
  function automatic bit next_channel(logic [DUTY_W:0] d);
    int n;
    n = active_channels();
    chan_now += rev ? -1 : 1;
    if (chan_now >= 0 && chan_now < n) begin
      duty_now = d;
      write_duty(duty_now);
    end
    return rev ? (chan_now < 0) : (chan_now >= n);
  endfunction

  function automatic bit fade_up();
    if (duty_now < tgt_duty) begin
      duty_now = duty_now + step;
      if (duty_now > tgt_duty) duty_now = tgt_duty;
      write_duty(duty_now);
      return 1'b0;
    end
    return next_channel('0);
  endfunction

  function automatic void start_walk(mode_t m, logic [DUTY_W:0] d0, bit stamp,
                                     logic [31:0] now_ms);
    pend      = 1'b1;
    walk_mode = m;
    if (stamp) stamp_ms = now_ms;
    duty_now  = d0;
    chan_now  = rev ? active_channels() - 1 : 0;
  endfunction

  function automatic result_t predict_fade(item_t it);
    result_t r;
    logic [31:0] since;
    wr_hit = 1'b0;
    wr_ch  = '0;
    wr_dt  = '0;
    case (it.operation)
      OP_ON: begin
        rev = it.reverse_order;
        if (!pend && !lamp) start_walk(MODE_ON, '0, 1'b1, it.now_ms);
      end
      OP_OFF: begin
        rev = it.reverse_order;
        if (!pend && lamp) start_walk(MODE_OFF, tgt_duty, 1'b1, it.now_ms);
      end
      OP_BLINK: begin
        rev = it.reverse_order;
        if (!pend) start_walk(MODE_BLINK, '0, 1'b0, it.now_ms);
      end
      OP_TOGGLE: begin
        rev = it.reverse_order;
        if (!pend) begin
          if (lamp) start_walk(MODE_OFF, tgt_duty, 1'b1, it.now_ms);
          else start_walk(MODE_ON, '0, 1'b1, it.now_ms);
        end
      end
      OP_TICK: begin
        case (walk_mode)
          MODE_ON: begin
            if (fade_up()) begin
              lamp      = 1'b1;
              pend      = 1'b0;
              walk_mode = MODE_IDLE;
            end
          end
          MODE_OFF: begin
            if (duty_now > 0) begin
              duty_now = (duty_now > step) ? duty_now - step : '0;
              write_duty(duty_now);
            end else if (next_channel(tgt_duty)) begin
              lamp      = 1'b0;
              pend      = 1'b0;
              walk_mode = MODE_IDLE;
            end
          end
          MODE_BLINK: begin
            since = it.now_ms - stamp_ms;
            if (!lamp) begin
              lamp     = fade_up();
              stamp_ms = it.now_ms;
            end else if (since >= hold_ms) begin
              start_walk(MODE_OFF, tgt_duty, 1'b1, it.now_ms);
            end
          end
          default: ;
        endcase
      end
      // spare operation codes leave everything untouched
      default: ;
    endcase
    r.pwm_write = wr_hit;
    r.channel   = wr_ch;
    r.duty      = wr_dt;
    r.lamp_on   = lamp;
    r.busy_res  = pend;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("write %0b ch %0d duty %0d on %0b busy %0b",
                     r.pwm_write, r.channel, r.duty, r.lamp_on, r.busy_res);
  endfunction

  task automatic log_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t fader check: %s", $time, msg);
  endtask

  // Register writes, result comparison, then prediction of the new beat
  always @(posedge clk) begin
    if (rst) begin
      tgt_duty   = 12'd4095;
      step       = 12'd20;
      hold_ms    = 32'd10000;
      chan_count = 5'd16;
      walk_mode  = MODE_IDLE;
      pend       = 1'b0;
      lamp       = 1'b0;
      rev        = 1'b0;
      duty_now   = '0;
      chan_now   = 0;
      stamp_ms   = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_TARGET_DUTY:   tgt_duty   = pwdata[DUTY_W-1:0];
          REG_RAMP_STEP:     step       = pwdata[DUTY_W-1:0];
          REG_HOLD_TIME:     hold_ms    = pwdata;
          REG_CHANNEL_COUNT: chan_count = pwdata[4:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          log_fault({"result beat with nothing expected: ", show(result)});
        end else begin
          oldest = expected_q.pop_front();
          if (result.pwm_write !== oldest.pwm_write || result.channel !== oldest.channel ||
              result.duty !== oldest.duty || result.lamp_on !== oldest.lamp_on ||
              result.busy_res !== oldest.busy_res)
            log_fault({"expected ", show(oldest), ", got ", show(result)});
        end
      end
      if (item_valid && !item_stall) expected_q.push_back(predict_fade(item));
    end
    awaiting = expected_q.size();
  end

endmodule

// File: test/sequential_channel_fader_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequential_channel_fader_tb : stimulus and verdict for the channel fader
// Runs a short directed sequence through every request and blink case, then
// random tick and request beats under several register settings, with random
// gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------

module sequential_channel_fader_tb;
  import scf_pkg::*;

  // Spare operation codes, ignored by the fader
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fault_count;
  int unsigned awaiting;
  bit          sender_gaps;
  bit          receiver_stalls;
  logic [31:0] clock_ms;

  sequential_channel_fader DUT (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fade_walk_monitor walk_monitor (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fault_count, .awaiting
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short idle spans, now and then a long one
  function automatic int unsigned idle_span();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
  endfunction

  function automatic item_t beat(logic [2:0] op, logic rev, logic [31:0] now_ms);
    item_t b;
    b.operation     = op;
    b.reverse_order = rev;
    b.now_ms        = now_ms;
    return b;
  endfunction

  // Mostly ticks on a slowly running clock, some requests, a few spare codes
  function automatic item_t random_beat();
    int unsigned pick;
    logic [2:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 74) op = OP_TICK;
    else if (pick < 94) op = 3'($urandom_range(OP_ON, OP_TOGGLE));
    else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    pick = $urandom_range(0, 99);
    if (pick < 80) clock_ms += $urandom_range(0, 4);
    else if (pick < 92) clock_ms += $urandom_range(0, 20000);
    else if (pick < 97) clock_ms = $urandom();
    else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 8);
    return beat(op, 1'($urandom_range(0, 1)), clock_ms);
  endfunction

  task automatic send_item(item_t it);
    int unsigned gap;
    @(negedge clk);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    gap = (sender_gaps && $urandom_range(0, 99) >= 55) ? idle_span() : 0;
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the sender off until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_settings(cfg_t s);
    write_reg(REG_TARGET_DUTY, 32'(s.target_duty));
    write_reg(REG_RAMP_STEP, 32'(s.ramp_step));
    write_reg(REG_HOLD_TIME, s.hold_time_ms);
    write_reg(REG_CHANNEL_COUNT, 32'(s.channel_count));
  endtask

  task automatic random_phase(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 79) == 0) drain();
      send_item(random_beat());
    end
  endtask

  // Result side: random stall bursts while enabled
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && !rst && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat (idle_span()) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Main sequence
  initial begin
    cfg_t s;
    rst             = 1'b1;
    item_valid      = 1'b0;
    item            = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    clock_ms        = $urandom();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one short channel, quick ramp and a three ms blink hold
    s.target_duty   = 12'd100;
    s.ramp_step     = 12'd50;
    s.hold_time_ms  = 32'd3;
    s.channel_count = 5'd1;
    write_settings(s);
    send_item(beat(OP_SPARE_FIRST, 1'b1, 32'hFFFF_FFFF));
    send_item(beat(OP_SPARE_LAST, 1'b0, 32'd0));
    send_item(beat(OP_TICK, 1'b1, 32'hFFFF_FFFF));
    send_item(beat(OP_OFF, 1'b0, 32'd0));          // refused: lamp off
    send_item(beat(OP_ON, 1'b1, 32'd0));
    send_item(beat(OP_TICK, 1'b0, 32'd1));
    send_item(beat(OP_ON, 1'b0, 32'd1));           // refused: busy, flips direction
    send_item(beat(OP_TICK, 1'b0, 32'd2));
    send_item(beat(OP_TICK, 1'b0, 32'd2));
    send_item(beat(OP_ON, 1'b1, 32'd2));           // refused: already on
    send_item(beat(OP_TOGGLE, 1'b0, 32'hFFFF_FFF0));
    repeat (3) send_item(beat(OP_TICK, 1'b1, 32'hFFFF_FFF1));
    send_item(beat(OP_BLINK, 1'b1, 32'd5));
    repeat (3) send_item(beat(OP_TICK, 1'b0, 32'hFFFF_FFFE));
    // hold is measured across the wrap of the ms counter
    send_item(beat(OP_TICK, 1'b0, 32'd0));
    send_item(beat(OP_TICK, 1'b0, 32'd1));
    repeat (3) send_item(beat(OP_TICK, 1'b1, 32'd2));
    send_item(beat(OP_TICK, 1'b0, 32'd3));
    drain();

    // Random phases under changing settings; walks may span phase changes
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: s = '{target_duty: 12'd4095, ramp_step: 12'd4095, hold_time_ms: 32'd0,
                 channel_count: 5'd16};
        1: s = '{target_duty: 12'd0, ramp_step: 12'd1, hold_time_ms: 32'd10,
                 channel_count: 5'd1};
        2: s = '{target_duty: 12'd4095, ramp_step: 12'd20, hold_time_ms: 32'd10000,
                 channel_count: 5'd16};
        3: s = '{target_duty: 12'($urandom_range(0, 4095)), ramp_step: 12'd0,
                 hold_time_ms: 32'hFFFF_FFFF, channel_count: 5'd0};
        4: s = '{target_duty: 12'd300, ramp_step: 12'd100, hold_time_ms: 32'd20,
                 channel_count: 5'd31};
        default: s = '{target_duty: 12'($urandom_range(0, 4095)),
                       ramp_step: 12'($urandom_range(1, 4095)),
                       hold_time_ms: 32'($urandom_range(0, 40)),
                       channel_count: 5'($urandom_range(1, 16))};
      endcase
      write_settings(s);
      // one phase runs with neither side idling
      sender_gaps     = (p != 2);
      receiver_stalls = (p != 2);
      random_phase(115);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("** sequential_channel_fader: PASSED **");
    end else begin
      $display("** sequential_channel_fader: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** sequential_channel_fader: FAILED **");
    $finish;
  end

endmodule
